// ----- sv/interval_timing_statistics_macros.svh -----
// ----------------------------------------------------------------------------
// Interval timing statistics assertion macros
// Shared concurrent assertion forms used by the interval timing statistics RTL.
// ----------------------------------------------------------------------------
`ifndef INTERVAL_TIMING_STATISTICS_MACROS_SVH
`define INTERVAL_TIMING_STATISTICS_MACROS_SVH

`ifndef SYNTH
`define ITS_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("interval timing statistics assertion failed");
`define ITS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("interval timing statistics assertion failed");
`else
`define ITS_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ITS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ----- sv/its_pkg.sv -----
// ----------------------------------------------------------------------------
// Interval timing statistics package
// Widths, event codes, queue entry type and back end states shared by the RTL.
// ----------------------------------------------------------------------------
package its_pkg;

   localparam int COUNT_WIDTH = 16;
   localparam int STAMP_WIDTH = 32;
   localparam int SUM_WIDTH   = 48;
   localparam int QUEUE_DEPTH = 2;
   localparam int DIV_STEPS   = SUM_WIDTH;
   localparam int STEP_WIDTH  = $clog2(DIV_STEPS);

   localparam logic [COUNT_WIDTH-1:0] RUNS_PER_REPORT_RESET = 16'd100;

   localparam logic [1:0] KIND_START = 2'd0;
   localparam logic [1:0] KIND_STOP  = 2'd1;
   localparam logic [1:0] KIND_FLUSH = 2'd2;

   typedef struct packed {
      logic                   report_valid;
      logic [COUNT_WIDTH-1:0] run_total;
      logic [STAMP_WIDTH-1:0] shortest;
      logic [STAMP_WIDTH-1:0] longest;
      logic [SUM_WIDTH-1:0]   sum_ticks;
   } job_type;

   typedef enum logic [1:0] {
      BACK_IDLE,
      BACK_DIVIDE,
      BACK_DONE
   } back_state_type;

endpackage

// ----- sv/interval_timing_statistics.sv -----
// ----------------------------------------------------------------------------
// Interval timing statistics
// Run count, minimum, maximum, total and mean of start-to-stop tick intervals.
// ----------------------------------------------------------------------------
// Start beats produce nothing. Stop and flush beats are folded into the
// statistics in the cycle they are accepted and leave a job in a short
// queue for the back end. A stop that does not complete a report is written
// to the result register at the edge it leaves the queue, which it does only
// while the back end is idle and the result register is free. A report with
// at least one run goes through a restoring divider that yields one quotient
// bit per cycle over the 48-bit total, then waits in the done state until the
// result register is free and is loaded into it. The back end takes no new
// job from the queue until the last one has been loaded. A report of zero
// runs skips the divider. The front end keeps taking beats while the divider
// works until the queue fills, at which point full is raised and every beat,
// start beats included, waits.
// ----------------------------------------------------------------------------
module interval_timing_statistics #(
   parameter int QueueDepth = its_pkg::QUEUE_DEPTH
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_push,
   output logic                            req_full,
   input  logic [1:0]                      req_kind,
   input  logic [its_pkg::STAMP_WIDTH-1:0] req_tick_stamp,
   output logic                            rsp_empty,
   input  logic                            rsp_pop,
   output logic                            rsp_report_valid,
   output logic [its_pkg::COUNT_WIDTH-1:0] rsp_run_total,
   output logic [its_pkg::STAMP_WIDTH-1:0] rsp_shortest,
   output logic [its_pkg::STAMP_WIDTH-1:0] rsp_longest,
   output logic [its_pkg::SUM_WIDTH-1:0]   rsp_sum_ticks,
   output logic [its_pkg::STAMP_WIDTH-1:0] rsp_mean_ticks,
   input  logic                            csr_we,
   input  logic [its_pkg::COUNT_WIDTH-1:0] csr_wdata
);

   logic             job_push;
   its_pkg::job_type job_in_data;
   logic             job_full;
   logic             job_pop;
   its_pkg::job_type job_out_data;
   logic             job_empty;

   its_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_kind       (req_kind),
      .req_tick_stamp (req_tick_stamp),
      .csr_we         (csr_we),
      .csr_wdata      (csr_wdata),
      .job_push       (job_push),
      .job_data       (job_in_data),
      .job_full       (job_full)
   );

   its_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_data (job_in_data),
      .full      (job_full),
      .pop       (job_pop),
      .pop_data  (job_out_data),
      .empty     (job_empty)
   );

   its_back u_back (
      .clock            (clock),
      .reset            (reset),
      .job_empty        (job_empty),
      .job_data         (job_out_data),
      .job_pop          (job_pop),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_report_valid (rsp_report_valid),
      .rsp_run_total    (rsp_run_total),
      .rsp_shortest     (rsp_shortest),
      .rsp_longest      (rsp_longest),
      .rsp_sum_ticks    (rsp_sum_ticks),
      .rsp_mean_ticks   (rsp_mean_ticks)
   );

endmodule

// ----- sv/its_queue.sv -----
// ----------------------------------------------------------------------------
// Interval timing statistics job queue
// Short first-in first-out queue of pending results between front and back.
// ----------------------------------------------------------------------------
module its_queue #(
   parameter int Depth = its_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  its_pkg::job_type push_data,
   output logic             full,
   input  logic             pop,
   output its_pkg::job_type pop_data,
   output logic             empty
);

   localparam int PtrWidth   = $clog2(Depth);
   localparam int CountWidth = $clog2(Depth + 1);

   its_pkg::job_type      entry_ff [Depth];
   logic [PtrWidth-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CountWidth-1:0] count_ff, count_in;
   logic                  do_push, do_pop;

   assign full     = (count_ff == CountWidth'(Depth));
   assign empty    = (count_ff == '0);
   assign pop_data = entry_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrWidth'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrWidth'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- sv/its_front.sv -----
// ----------------------------------------------------------------------------
// Interval timing statistics front end
// Accepts event beats, keeps the running statistics and queues result jobs.
// ----------------------------------------------------------------------------
module its_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_push,
   output logic                              req_full,
   input  logic [1:0]                        req_kind,
   input  logic [its_pkg::STAMP_WIDTH-1:0]   req_tick_stamp,
   input  logic                              csr_we,
   input  logic [its_pkg::COUNT_WIDTH-1:0]   csr_wdata,
   output logic                              job_push,
   output its_pkg::job_type                  job_data,
   input  logic                              job_full
);

   logic [its_pkg::COUNT_WIDTH-1:0] rpr_ff, rpr_in;
   logic [its_pkg::STAMP_WIDTH-1:0] start_ff, start_in;
   logic [its_pkg::COUNT_WIDTH-1:0] count_ff, count_in;
   logic [its_pkg::STAMP_WIDTH-1:0] min_ff, min_in;
   logic [its_pkg::STAMP_WIDTH-1:0] max_ff, max_in;
   logic [its_pkg::SUM_WIDTH-1:0]   sum_ff, sum_in;

   logic                            accept;
   logic                            first_run;
   logic                            hit;
   logic [its_pkg::STAMP_WIDTH-1:0] elapsed;
   logic [its_pkg::STAMP_WIDTH-1:0] min_upd, max_upd;
   logic [its_pkg::COUNT_WIDTH-1:0] count_upd;
   logic [its_pkg::SUM_WIDTH-1:0]   sum_upd;

   assign req_full = job_full;
   assign accept   = req_push && !job_full;

   always_comb begin
      elapsed   = req_tick_stamp - start_ff;
      first_run = (count_ff == '0);
      min_upd   = (first_run || (elapsed < min_ff)) ? elapsed : min_ff;
      max_upd   = (first_run || (elapsed > max_ff)) ? elapsed : max_ff;
      count_upd = count_ff + 1'b1;
      sum_upd   = sum_ff + {{(its_pkg::SUM_WIDTH - its_pkg::STAMP_WIDTH){1'b0}}, elapsed};
      hit       = (count_upd >= rpr_ff);

      rpr_in   = csr_we ? csr_wdata : rpr_ff;
      start_in = start_ff;
      count_in = count_ff;
      min_in   = min_ff;
      max_in   = max_ff;
      sum_in   = sum_ff;
      job_push = 1'b0;
      job_data = '0;

      if (accept) begin
         case (req_kind)
            its_pkg::KIND_START: begin
               start_in = req_tick_stamp;
            end
            its_pkg::KIND_STOP: begin
               job_push = 1'b1;
               if (hit) begin
                  job_data = '{report_valid: 1'b1, run_total: count_upd,
                               shortest: min_upd, longest: max_upd, sum_ticks: sum_upd};
                  count_in = '0;
                  min_in   = '0;
                  max_in   = '0;
                  sum_in   = '0;
               end else begin
                  count_in = count_upd;
                  min_in   = min_upd;
                  max_in   = max_upd;
                  sum_in   = sum_upd;
               end
            end
            its_pkg::KIND_FLUSH: begin
               job_push = 1'b1;
               job_data = '{report_valid: 1'b1, run_total: count_ff,
                            shortest: min_ff, longest: max_ff, sum_ticks: sum_ff};
               count_in = '0;
               min_in   = '0;
               max_in   = '0;
               sum_in   = '0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rpr_ff   <= its_pkg::RUNS_PER_REPORT_RESET;
         start_ff <= '0;
         count_ff <= '0;
         min_ff   <= '0;
         max_ff   <= '0;
         sum_ff   <= '0;
      end else begin
         rpr_ff   <= rpr_in;
         start_ff <= start_in;
         count_ff <= count_in;
         min_ff   <= min_in;
         max_ff   <= max_in;
         sum_ff   <= sum_in;
      end
   end

endmodule

// ----- sv/its_back.sv -----
// ----------------------------------------------------------------------------
// Interval timing statistics back end
// Takes queued jobs, divides total by count one bit per cycle, holds results.
// ----------------------------------------------------------------------------
`include "interval_timing_statistics_macros.svh"

module its_back (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            job_empty,
   input  its_pkg::job_type                job_data,
   output logic                            job_pop,
   output logic                            rsp_empty,
   input  logic                            rsp_pop,
   output logic                            rsp_report_valid,
   output logic [its_pkg::COUNT_WIDTH-1:0] rsp_run_total,
   output logic [its_pkg::STAMP_WIDTH-1:0] rsp_shortest,
   output logic [its_pkg::STAMP_WIDTH-1:0] rsp_longest,
   output logic [its_pkg::SUM_WIDTH-1:0]   rsp_sum_ticks,
   output logic [its_pkg::STAMP_WIDTH-1:0] rsp_mean_ticks
);

   its_pkg::back_state_type         state_ff, state_in;
   its_pkg::job_type                hold_ff, hold_in;
   logic [its_pkg::SUM_WIDTH-1:0]   quot_ff, quot_in;
   logic [its_pkg::COUNT_WIDTH-1:0] rem_ff, rem_in;
   logic [its_pkg::STEP_WIDTH-1:0]  step_ff, step_in;
   logic                            out_valid_ff, out_valid_in;
   its_pkg::job_type                out_job_ff, out_job_in;
   logic [its_pkg::STAMP_WIDTH-1:0] out_mean_ff, out_mean_in;

   logic                            out_free;
   logic                            needs_div;
   logic                            start_div;
   logic                            load_direct;
   logic                            load_done;
   logic [its_pkg::COUNT_WIDTH:0]   trial;
   logic [its_pkg::COUNT_WIDTH:0]   diff;
   logic                            ge;

   assign out_free  = !out_valid_ff || rsp_pop;
   assign needs_div = job_data.report_valid && (job_data.run_total != '0);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         its_pkg::BACK_IDLE: begin
            if (!job_empty && out_free && needs_div) begin
               state_in = its_pkg::BACK_DIVIDE;
            end
         end
         its_pkg::BACK_DIVIDE: begin
            if (step_ff == '0) begin
               state_in = its_pkg::BACK_DONE;
            end
         end
         its_pkg::BACK_DONE: begin
            if (out_free) begin
               state_in = its_pkg::BACK_IDLE;
            end
         end
         default: begin
            state_in = its_pkg::BACK_IDLE;
         end
      endcase
   end

   always_comb begin
      job_pop     = 1'b0;
      load_done   = 1'b0;
      case (state_ff)
         its_pkg::BACK_IDLE: begin
            job_pop = !job_empty && out_free;
         end
         its_pkg::BACK_DONE: begin
            load_done = out_free;
         end
         default: begin
         end
      endcase
      start_div   = job_pop && needs_div;
      load_direct = job_pop && !needs_div;
   end

   always_comb begin
      trial = {rem_ff, quot_ff[its_pkg::SUM_WIDTH-1]};
      ge    = (trial >= {1'b0, hold_ff.run_total});
      diff  = trial - {1'b0, hold_ff.run_total};

      hold_in = hold_ff;
      quot_in = quot_ff;
      rem_in  = rem_ff;
      step_in = step_ff;
      if (start_div) begin
         hold_in = job_data;
         quot_in = job_data.sum_ticks;
         rem_in  = '0;
         step_in = its_pkg::STEP_WIDTH'(its_pkg::DIV_STEPS - 1);
      end else if (state_ff == its_pkg::BACK_DIVIDE) begin
         quot_in = {quot_ff[its_pkg::SUM_WIDTH-2:0], ge};
         rem_in  = ge ? diff[its_pkg::COUNT_WIDTH-1:0] : trial[its_pkg::COUNT_WIDTH-1:0];
         step_in = step_ff - 1'b1;
      end

      out_job_in   = out_job_ff;
      out_mean_in  = out_mean_ff;
      out_valid_in = out_valid_ff && !rsp_pop;
      if (load_direct) begin
         out_job_in   = job_data;
         out_mean_in  = '0;
         out_valid_in = 1'b1;
      end else if (load_done) begin
         out_job_in   = hold_ff;
         out_mean_in  = quot_ff[its_pkg::STAMP_WIDTH-1:0];
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= its_pkg::BACK_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hold_ff     <= hold_in;
      quot_ff     <= quot_in;
      rem_ff      <= rem_in;
      step_ff     <= step_in;
      out_job_ff  <= out_job_in;
      out_mean_ff <= out_mean_in;
   end

   assign rsp_empty        = !out_valid_ff;
   assign rsp_report_valid = out_job_ff.report_valid;
   assign rsp_run_total    = out_job_ff.run_total;
   assign rsp_shortest     = out_job_ff.shortest;
   assign rsp_longest      = out_job_ff.longest;
   assign rsp_sum_ticks    = out_job_ff.sum_ticks;
   assign rsp_mean_ticks   = out_mean_ff;

   `ITS_ASSERT_IMPLY(divisor_nonzero, clock, reset,
                     state_ff == its_pkg::BACK_DIVIDE, hold_ff.run_total != '0)
   `ITS_ASSERT_NEXT(divide_ends, clock, reset,
                    (state_ff == its_pkg::BACK_DIVIDE) && (step_ff == '0),
                    state_ff == its_pkg::BACK_DONE)
   `ITS_ASSERT_NEXT(direct_load_shows, clock, reset,
                    load_direct, out_valid_ff && (state_ff == its_pkg::BACK_IDLE))

endmodule

// ----- sim/interval_timing_statistics_tb.sv -----
// ----------------------------------------------------------------------------
// Interval timing statistics testbench
// Drives start, stop and flush beats into the block through its queue-style
// handshake, predicts every result with a local model of the statistics, and
// compares each popped result field by field. Covers the reset threshold,
// threshold extremes, a lowered threshold, tick wraparound, random traffic
// under several idle and stall mixes, and a long receiver hold-off.
// ----------------------------------------------------------------------------
module interval_timing_statistics_tb;

   localparam logic [1:0] KIND_UNUSED   = 2'd3;
   localparam int         SETTLE_CYCLES = 8;
   localparam int         TIMEOUT_UNITS = 4_000_000;

   typedef struct packed {
      logic                            report_valid;
      logic [its_pkg::COUNT_WIDTH-1:0] run_total;
      logic [its_pkg::STAMP_WIDTH-1:0] shortest;
      logic [its_pkg::STAMP_WIDTH-1:0] longest;
      logic [its_pkg::SUM_WIDTH-1:0]   sum_ticks;
      logic [its_pkg::STAMP_WIDTH-1:0] mean_ticks;
   } timing_report_type;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_push = 1'b0;
   logic                            req_full;
   logic [1:0]                      req_kind = its_pkg::KIND_START;
   logic [its_pkg::STAMP_WIDTH-1:0] req_tick_stamp = '0;
   logic                            rsp_empty;
   logic                            rsp_pop = 1'b0;
   logic                            rsp_report_valid;
   logic [its_pkg::COUNT_WIDTH-1:0] rsp_run_total;
   logic [its_pkg::STAMP_WIDTH-1:0] rsp_shortest;
   logic [its_pkg::STAMP_WIDTH-1:0] rsp_longest;
   logic [its_pkg::SUM_WIDTH-1:0]   rsp_sum_ticks;
   logic [its_pkg::STAMP_WIDTH-1:0] rsp_mean_ticks;
   logic                            csr_we = 1'b0;
   logic [its_pkg::COUNT_WIDTH-1:0] csr_wdata = '0;

   // Local copy of the statistics state and the threshold register.
   logic [its_pkg::COUNT_WIDTH-1:0] model_threshold;
   logic [its_pkg::STAMP_WIDTH-1:0] model_start_mark;
   logic [its_pkg::COUNT_WIDTH-1:0] model_runs;
   logic [its_pkg::STAMP_WIDTH-1:0] model_fastest;
   logic [its_pkg::STAMP_WIDTH-1:0] model_slowest;
   logic [its_pkg::SUM_WIDTH-1:0]   model_tick_total;

   timing_report_type pending_results[$];

   int send_idle_pct = 0;
   int pop_stall_pct = 0;
   int hold_len = 0;
   int hold_ticket = 0;
   int hold_seen = 0;
   int hold_left = 0;

   int fail_count = 0;
   int beats_accepted = 0;
   int results_checked = 0;
   int reports_seen = 0;
   int threshold_writes = 0;

   interval_timing_statistics dut (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_kind         (req_kind),
      .req_tick_stamp   (req_tick_stamp),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_report_valid (rsp_report_valid),
      .rsp_run_total    (rsp_run_total),
      .rsp_shortest     (rsp_shortest),
      .rsp_longest      (rsp_longest),
      .rsp_sum_ticks    (rsp_sum_ticks),
      .rsp_mean_ticks   (rsp_mean_ticks),
      .csr_we           (csr_we),
      .csr_wdata        (csr_wdata)
   );

   always #2 clock = ~clock;

   function automatic timing_report_type close_report();
      timing_report_type rep;
      logic [its_pkg::SUM_WIDTH-1:0] quotient;
      quotient = '0;
      if (model_runs != 0) begin
         quotient = model_tick_total
                  / {{(its_pkg::SUM_WIDTH-its_pkg::COUNT_WIDTH){1'b0}}, model_runs};
      end
      rep.report_valid = 1'b1;
      rep.run_total    = model_runs;
      rep.shortest     = model_fastest;
      rep.longest      = model_slowest;
      rep.sum_ticks    = model_tick_total;
      rep.mean_ticks   = quotient[its_pkg::STAMP_WIDTH-1:0];
      model_runs       = '0;
      model_fastest    = '0;
      model_slowest    = '0;
      model_tick_total = '0;
      return rep;
   endfunction

   function automatic void fold_event(input logic [1:0] kind,
                                      input logic [its_pkg::STAMP_WIDTH-1:0] stamp,
                                      output logic produced,
                                      output timing_report_type rep);
      logic [its_pkg::STAMP_WIDTH-1:0] elapsed;
      produced = 1'b0;
      rep = '0;
      case (kind)
         its_pkg::KIND_START: begin
            model_start_mark = stamp;
         end
         its_pkg::KIND_FLUSH: begin
            produced = 1'b1;
            rep = close_report();
         end
         its_pkg::KIND_STOP: begin
            produced = 1'b1;
            elapsed = stamp - model_start_mark;
            if (model_runs == 0) begin
               model_fastest = elapsed;
               model_slowest = elapsed;
            end else begin
               if (elapsed > model_slowest) model_slowest = elapsed;
               if (elapsed < model_fastest) model_fastest = elapsed;
            end
            model_runs = model_runs + 1'b1;
            model_tick_total = model_tick_total
                             + {{(its_pkg::SUM_WIDTH-its_pkg::STAMP_WIDTH){1'b0}}, elapsed};
            if (model_runs >= model_threshold) rep = close_report();
         end
         default: begin
         end
      endcase
   endfunction

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (want !== got) begin
         $error("%s expected 0x%0h got 0x%0h", name, want, got);
         fail_count++;
      end
   endtask

   // Result checking and prediction share one process so that a result is
   // always compared before a beat accepted at the same edge is predicted.
   always @(posedge clock) begin : result_monitor
      timing_report_type got;
      timing_report_type want;
      logic produced;
      if (reset) begin
         model_threshold  = its_pkg::RUNS_PER_REPORT_RESET;
         model_start_mark = '0;
         model_runs       = '0;
         model_fastest    = '0;
         model_slowest    = '0;
         model_tick_total = '0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            got.report_valid = rsp_report_valid;
            got.run_total    = rsp_run_total;
            got.shortest     = rsp_shortest;
            got.longest      = rsp_longest;
            got.sum_ticks    = rsp_sum_ticks;
            got.mean_ticks   = rsp_mean_ticks;
            if (pending_results.size() == 0) begin
               $error("result beat arrived with no result expected");
               fail_count++;
            end else begin
               want = pending_results.pop_front();
               check_field("report_valid", 64'(want.report_valid), 64'(got.report_valid));
               check_field("run_total", 64'(want.run_total), 64'(got.run_total));
               check_field("shortest", 64'(want.shortest), 64'(got.shortest));
               check_field("longest", 64'(want.longest), 64'(got.longest));
               check_field("sum_ticks", 64'(want.sum_ticks), 64'(got.sum_ticks));
               check_field("mean_ticks", 64'(want.mean_ticks), 64'(got.mean_ticks));
               results_checked++;
               if (want.report_valid) reports_seen++;
            end
         end
         if (csr_we) model_threshold = csr_wdata;
         if (req_push && !req_full) begin
            beats_accepted++;
            fold_event(req_kind, req_tick_stamp, produced, want);
            if (produced) pending_results.push_back(want);
         end
      end
   end

   always @(posedge clock) begin
      if (hold_ticket != hold_seen) begin
         hold_seen <= hold_ticket;
         hold_left <= hold_len;
         rsp_pop   <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_pop   <= 1'b0;
      end else begin
         rsp_pop <= ($urandom_range(99) >= pop_stall_pct);
      end
   end

   // Called at a rising edge; returns at the edge where the beat is taken,
   // leaving push high so the next beat can follow without a gap.
   task automatic send_beat(input logic [1:0] kind,
                            input logic [its_pkg::STAMP_WIDTH-1:0] stamp);
      while ($urandom_range(99) < send_idle_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push       <= 1'b1;
      req_kind       <= kind;
      req_tick_stamp <= stamp;
      do @(posedge clock); while (req_full);
   endtask

   task automatic settle();
      req_push <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_threshold(input logic [its_pkg::COUNT_WIDTH-1:0] value);
      settle();
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      threshold_writes++;
   endtask

   function automatic logic [its_pkg::STAMP_WIDTH-1:0] pick_elapsed();
      case ($urandom_range(3))
         0:       return $urandom_range(255);
         1:       return $urandom;
         2:       return 32'hFFFF_FFFF - $urandom_range(255);
         default: return $urandom_range(65535);
      endcase
   endfunction

   task automatic test_directed();
      send_idle_pct = 0;
      pop_stall_pct = 0;
      send_beat(its_pkg::KIND_STOP, 32'h0000_0010);
      send_beat(its_pkg::KIND_FLUSH, 32'h0000_0000);
      send_beat(its_pkg::KIND_FLUSH, 32'hFFFF_FFFF);
      send_beat(its_pkg::KIND_START, 32'hFFFF_FFF0);
      send_beat(its_pkg::KIND_STOP, 32'h0000_0010);
      send_beat(its_pkg::KIND_STOP, 32'h0000_0030);
      send_beat(its_pkg::KIND_START, 32'h0000_0000);
      send_beat(its_pkg::KIND_STOP, 32'hFFFF_FFFF);
      send_beat(its_pkg::KIND_START, 32'h1234_5678);
      send_beat(its_pkg::KIND_STOP, 32'h1234_5678);
      send_beat(KIND_UNUSED, 32'hFFFF_FFFF);
      send_beat(KIND_UNUSED, 32'h0000_0000);
      send_beat(its_pkg::KIND_FLUSH, 32'h0000_0000);
      send_beat(its_pkg::KIND_START, 32'hAAAA_AAAA);
      send_beat(its_pkg::KIND_STOP, 32'h5555_5555);
      send_beat(its_pkg::KIND_FLUSH, 32'h5555_5555);
      settle();
   endtask

   task automatic test_thresholds();
      logic [its_pkg::STAMP_WIDTH-1:0] mark;
      write_threshold(16'd1);
      repeat (3) begin
         mark = $urandom;
         send_beat(its_pkg::KIND_START, mark);
         send_beat(its_pkg::KIND_STOP, mark + pick_elapsed());
      end
      write_threshold(16'd0);
      repeat (2) begin
         mark = $urandom;
         send_beat(its_pkg::KIND_START, mark);
         send_beat(its_pkg::KIND_STOP, mark + pick_elapsed());
      end
      send_beat(its_pkg::KIND_FLUSH, $urandom);
      // Repeated stops of the longest interval push the total past 32 bits.
      write_threshold(16'hFFFF);
      send_beat(its_pkg::KIND_START, 32'h0000_0000);
      repeat (12) send_beat(its_pkg::KIND_STOP, 32'hFFFF_FFFF);
      send_beat(its_pkg::KIND_STOP, 32'h0000_0007);
      send_beat(its_pkg::KIND_FLUSH, 32'h0000_0000);
      // Lowering the threshold below the current count reports on the next stop.
      write_threshold(16'd10);
      repeat (5) begin
         mark = $urandom;
         send_beat(its_pkg::KIND_START, mark);
         send_beat(its_pkg::KIND_STOP, mark + pick_elapsed());
      end
      write_threshold(16'd2);
      mark = $urandom;
      send_beat(its_pkg::KIND_START, mark);
      send_beat(its_pkg::KIND_STOP, mark + pick_elapsed());
      settle();
   endtask

   task automatic run_phase(input int idle_pct, input int stall_pct,
                            input logic [its_pkg::COUNT_WIDTH-1:0] threshold,
                            input int beats);
      int sent;
      int stops;
      logic [1:0] kind;
      logic [its_pkg::STAMP_WIDTH-1:0] mark;
      write_threshold(threshold);
      send_idle_pct = idle_pct;
      pop_stall_pct = stall_pct;
      sent = 0;
      while (sent < beats) begin
         if ($urandom_range(99) < 80) begin
            mark = $urandom;
            send_beat(its_pkg::KIND_START, mark);
            stops = $urandom_range(1, 3);
            repeat (stops) send_beat(its_pkg::KIND_STOP, mark + pick_elapsed());
            sent += stops + 1;
            if ($urandom_range(7) == 0) begin
               send_beat(its_pkg::KIND_FLUSH, $urandom);
               sent++;
            end
         end else begin
            kind = 2'($urandom_range(3));
            send_beat(kind, $urandom);
            if (kind != KIND_UNUSED) sent++;
         end
      end
      settle();
   endtask

   task automatic test_random_traffic();
      run_phase(0, 0, 16'd5, 180);
      run_phase(72, 0, 16'd1, 180);
      run_phase(0, 72, 16'($urandom_range(2, 16)), 180);
      run_phase(18, 18, 16'hFFFF, 180);
   endtask

   task automatic test_receiver_hold();
      logic [its_pkg::STAMP_WIDTH-1:0] mark;
      write_threshold(16'd1);
      send_idle_pct = 0;
      pop_stall_pct = 0;
      @(negedge clock);
      hold_len = 400;
      hold_ticket = hold_ticket + 1;
      @(posedge clock);
      repeat (20) begin
         mark = $urandom;
         send_beat(its_pkg::KIND_START, mark);
         send_beat(its_pkg::KIND_STOP, mark + pick_elapsed());
      end
      settle();
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_thresholds();
      test_random_traffic();
      test_receiver_hold();
      if (pending_results.size() != 0) begin
         $error("%0d expected results never arrived", pending_results.size());
         fail_count++;
      end
      $display("Accepted %0d beats and checked %0d results, %0d of them reports,",
               beats_accepted, results_checked, reports_seen);
      $display("across %0d threshold settings, four idle mixes and one long hold-off.",
               threshold_writes);
      if (fail_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   initial begin
      #(TIMEOUT_UNITS);
      $display("Timed out with %0d results outstanding.", pending_results.size());
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
